// ===== rtl/core/ps2i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ps2i_pkg;

  // sample_format codes
  localparam logic [2:0] FMT_INT16 = 3'd0;
  localparam logic [2:0] FMT_INT24 = 3'd1;
  localparam logic [2:0] FMT_INT32 = 3'd2;
  localparam logic [2:0] FMT_F32   = 3'd3;
  localparam logic [2:0] FMT_F64   = 3'd4;

  localparam logic [22:0] FULL_SCALE = 23'd8388607;
  localparam logic [10:0] EXP_ONE    = 11'd1023;
  localparam logic [10:0] EXP_BASE   = 11'd1075;
  localparam logic [10:0] EXP_F32ADJ = 11'd896;

  // per-request control that travels with the mantissa
  typedef struct packed {
    logic        byp;      // result already known
    logic [23:0] byp_val;
    logic        neg;
    logic [6:0]  sh_s;     // 1075 - exponent
  } ps2i_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/ps2i_fscale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2i_fscale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_vld,
  input  wire logic [52:0]          mant,
  input  wire ps2i_pkg::ps2i_ctl_t  ctl,
  output logic                      out_vld,
  output logic [23:0]               out_val
);

  logic                 v2, v3, v4;
  ps2i_pkg::ps2i_ctl_t  c2, c3, c4;
  logic [49:0]          pp_hi;
  logic [48:0]          pp_lo;
  logic [75:0]          q;
  logic [53:0]          r;
  logic [6:0]           sh;

  // rounding of the exact product to 53 bits
  logic [52:0] keep;
  logic        half, sticky, rnd_up;
  logic [6:0]  sh_next;
  always_comb begin
    if (q[75]) begin
      keep    = q[75:23];
      half    = q[22];
      sticky  = |q[21:0];
      sh_next = c3.sh_s - 7'd23;
    end else begin
      keep    = q[74:22];
      half    = q[21];
      sticky  = |q[20:0];
      sh_next = c3.sh_s - 7'd22;
    end
    rnd_up = half & (sticky | keep[0]);
  end

  // truncation toward zero and sign
  logic [53:0] shifted;
  logic [23:0] mag;
  always_comb begin
    shifted = r >> sh;
    mag     = (sh >= 7'd54) ? 24'd0 : shifted[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v2      <= in_vld;
      v3      <= v2;
      v4      <= v3;
      out_vld <= v4;
    end
  end

  // partial products, sum, round, shift
  always_ff @(posedge clk) begin
    pp_hi <= 50'(mant[52:26]) * 50'(ps2i_pkg::FULL_SCALE);
    pp_lo <= 49'(mant[25:0]) * 49'(ps2i_pkg::FULL_SCALE);
    c2    <= ctl;
    q     <= ({26'd0, pp_hi} << 26) + {27'd0, pp_lo};
    c3    <= c2;
    r     <= {1'b0, keep} + {53'd0, rnd_up};
    sh    <= sh_next;
    c4    <= c3;
    if (c4.byp) begin
      out_val <= c4.byp_val;
    end else begin
      out_val <= c4.neg ? (24'd0 - mag) : mag;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pcm_sample_to_int24_top.sv =====
// PCM sample to 24-bit integer converter. One request per cycle is taken
// (busy is never raised) and each result appears on sample_value with done
// high for one cycle; the latency is set by the five-stage float datapath
// (decode, split 53x23 multiply, sum, round, shift). The receiver cannot
// stall. Write sample_format through the cfg channel only while no request
// is in flight.
`timescale 1ns / 1ps
`default_nettype none
module pcm_sample_to_int24_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] container_word,
  output logic             done,
  output logic signed [23:0] sample_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  logic [2:0] sample_format;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= ps2i_pkg::FMT_INT16;
    end else if (cfg_valid && cfg_ready) begin
      sample_format <= cfg_data;
    end
  end

  // decode stage
  ps2i_pkg::ps2i_ctl_t ctl_next, ctl;
  logic [52:0]         m_next, m;
  logic                v1;
  logic [10:0]         e;
  logic                is_flt, is_nan, is_inf, is_zero;
  logic [10:0]         s_full;

  always_comb begin
    ctl_next = '0;
    m_next   = '0;
    e        = '0;
    is_flt   = 1'b0;
    is_nan   = 1'b0;
    is_inf   = 1'b0;
    is_zero  = 1'b0;
    s_full   = '0;
    unique case (sample_format)
      ps2i_pkg::FMT_INT16: begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = {{8{container_word[15]}}, container_word[15:0]};
      end
      ps2i_pkg::FMT_INT24: begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = container_word[23:0];
      end
      ps2i_pkg::FMT_INT32: begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = container_word[31:8];
      end
      ps2i_pkg::FMT_F32: begin
        is_flt       = 1'b1;
        ctl_next.neg = container_word[31];
        m_next       = {1'b1, container_word[22:0], 29'd0};
        is_nan       = (container_word[30:23] == 8'hff) && (container_word[22:0] != '0);
        is_inf       = (container_word[30:23] == 8'hff) && (container_word[22:0] == '0);
        is_zero      = (container_word[30:23] == 8'h00);
        e            = {3'd0, container_word[30:23]} + ps2i_pkg::EXP_F32ADJ;
      end
      ps2i_pkg::FMT_F64: begin
        is_flt       = 1'b1;
        ctl_next.neg = container_word[63];
        m_next       = {1'b1, container_word[51:0]};
        is_nan       = (container_word[62:52] == 11'h7ff) && (container_word[51:0] != '0);
        is_inf       = (container_word[62:52] == 11'h7ff) && (container_word[51:0] == '0);
        is_zero      = (container_word[62:52] == 11'h000);
        e            = container_word[62:52];
      end
      default: begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = 24'd0;
      end
    endcase
    if (is_flt) begin
      s_full        = ps2i_pkg::EXP_BASE - e;
      ctl_next.sh_s = s_full[6:0];
      priority if (is_nan || is_zero) begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = 24'd0;
      end else if (is_inf || (e >= ps2i_pkg::EXP_ONE)) begin
        // clamped to +-1.0
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = ctl_next.neg ? (24'd0 - {1'b0, ps2i_pkg::FULL_SCALE})
                                        : {1'b0, ps2i_pkg::FULL_SCALE};
      end else if (s_full >= 11'd127) begin
        ctl_next.byp     = 1'b1;
        ctl_next.byp_val = 24'd0;
      end else begin
        ctl_next.byp = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ctl <= ctl_next;
    m   <= m_next;
  end

  logic [23:0] val_raw;

  ps2i_fscale u_fscale (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v1),
    .mant    (m),
    .ctl     (ctl),
    .out_vld (done),
    .out_val (val_raw)
  );

  assign sample_value = val_raw;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("result missing five cycles after request");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without request");

  a_int16: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (sample_format == ps2i_pkg::FMT_INT16)) |-> ##5
      (sample_value == $past({{8{container_word[15]}}, container_word[15:0]}, 5)))
    else $error("int16 sign extension wrong");

endmodule
`default_nettype wire

// ===== test/tb_pcm_sample_to_int24_top.sv =====
`timescale 1ns / 1ps
module tb_pcm_sample_to_int24_top;

  // format codes the block leaves undefined
  localparam logic [2:0] FMT_RSVD5 = 3'd5;
  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [63:0]        container_word;
  logic               done;
  logic signed [23:0] sample_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data;

  logic [2:0]         cur_format;
  logic signed [23:0] sample_queue[$];
  int                 err_count;
  int                 cycle_count;
  int                 sender_idle_pct;

  typedef struct {
    logic [2:0]         fmt;
    logic [63:0]        word;
    bit                 typed;
    logic signed [23:0] value;
  } vec_t;

  pcm_sample_to_int24_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .container_word(container_word), .done(done), .sample_value(sample_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // clamp, scale by full scale in double precision, truncate toward zero
  function automatic logic signed [23:0] scale_real(real d);
    int v;
    if (d != d) return '0;
    if (d > 1.0) d = 1.0;
    if (d < -1.0) d = -1.0;
    v = $rtoi(d * 8388607.0);
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] convert_sample(logic [2:0] fmt, logic [63:0] w);
    logic [7:0]  e8;
    logic [10:0] e11;
    case (fmt)
      ps2i_pkg::FMT_INT16: return {{8{w[15]}}, w[15:0]};
      ps2i_pkg::FMT_INT24: return w[23:0];
      ps2i_pkg::FMT_INT32: return w[31:8];
      ps2i_pkg::FMT_F32: begin
        e8 = w[30:23];
        // zero and subnormals scale to well under one step
        if (e8 == 8'd0) return '0;
        if (e8 == 8'hff) begin
          if (w[22:0] != '0) return '0;
          return w[31] ? -24'sd8388607 : 24'sd8388607;
        end
        e11 = {3'b0, e8} + ps2i_pkg::EXP_F32ADJ;
        return scale_real($bitstoreal({w[31], e11, w[22:0], 29'b0}));
      end
      ps2i_pkg::FMT_F64: return scale_real($bitstoreal(w));
      default: return '0;
    endcase
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sample_queue.size() == 0) begin
        $error("sample_value: unexpected result %0d", sample_value);
        err_count++;
      end else begin
        if (sample_value !== sample_queue[0]) begin
          $error("sample_value: expected %0d actual %0d", sample_queue[0], sample_value);
          err_count++;
        end
        void'(sample_queue.pop_front());
      end
    end
  end

  task automatic write_format(logic [2:0] fmt);
    wait (sample_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_format = fmt;
  endtask

  // one request; idles first at the sender's rate
  task automatic send_word(logic [63:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    container_word <= w;
    do @(posedge clk); while (busy);
    sample_queue.push_back(convert_sample(cur_format, w));
  endtask

  function automatic logic [63:0] rand_word(logic [2:0] fmt);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      // keep floats near the unit range
      if (fmt == ps2i_pkg::FMT_F32) w[30:23] = 8'($urandom_range(100, 128));
      if (fmt == ps2i_pkg::FMT_F64) w[62:52] = 11'($urandom_range(990, 1025));
    end
    return w;
  endfunction

  vec_t vecs[] = '{
    '{ps2i_pkg::FMT_INT16, 64'h0,                  1, 24'sd0},
    '{ps2i_pkg::FMT_INT16, 64'h7fff,               1, 24'sd32767},
    '{ps2i_pkg::FMT_INT16, 64'hffff_ffff_ffff_8000, 1, -24'sd32768},
    '{ps2i_pkg::FMT_INT24, 64'h7f_ffff,            1, 24'sd8388607},
    '{ps2i_pkg::FMT_INT24, 64'hffff_ffff_ff80_0000, 1, -24'sd8388608},
    '{ps2i_pkg::FMT_INT32, 64'h7fff_ffff,          1, 24'sd8388607},
    '{ps2i_pkg::FMT_INT32, 64'h8000_0000,          1, -24'sd8388608},
    '{ps2i_pkg::FMT_INT32, 64'hff,                 1, 24'sd0},
    '{ps2i_pkg::FMT_F32,   64'h3f80_0000,          1, 24'sd8388607},
    '{ps2i_pkg::FMT_F32,   64'hbf80_0000,          1, -24'sd8388607},
    '{ps2i_pkg::FMT_F32,   64'h7f80_0000,          1, 24'sd8388607},
    '{ps2i_pkg::FMT_F32,   64'hff80_0000,          1, -24'sd8388607},
    '{ps2i_pkg::FMT_F32,   64'h7fc0_0000,          1, 24'sd0},
    '{ps2i_pkg::FMT_F32,   64'h3f00_0000,          1, 24'sd4194303},
    '{ps2i_pkg::FMT_F32,   64'hbe12_3457,          0, 24'sd0},
    '{ps2i_pkg::FMT_F64,   64'h3ff0_0000_0000_0000, 1, 24'sd8388607},
    '{ps2i_pkg::FMT_F64,   64'hfff0_0000_0000_0000, 1, -24'sd8388607},
    '{ps2i_pkg::FMT_F64,   64'h7ff8_0000_0000_0000, 1, 24'sd0},
    '{ps2i_pkg::FMT_F64,   64'h4000_0000_0000_0000, 1, 24'sd8388607},
    '{ps2i_pkg::FMT_F64,   64'h1,                  1, 24'sd0},
    '{ps2i_pkg::FMT_F64,   64'hbfd5_5555_5555_5555, 0, 24'sd0},
    '{FMT_RSVD5,           64'hffff_ffff_ffff_ffff, 1, 24'sd0},
    '{FMT_RSVD7,           64'h1234_5678_9abc_def0, 1, 24'sd0}
  };

  // stimulus
  initial begin
    logic [2:0] fmt;
    start          <= 1'b0;
    container_word <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    err_count       = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    cur_format      = ps2i_pkg::FMT_INT16;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (vecs[i]) begin
      if (vecs[i].fmt != cur_format) begin
        start <= 1'b0;
        write_format(vecs[i].fmt);
      end
      if (vecs[i].typed &&
          vecs[i].value !== convert_sample(vecs[i].fmt, vecs[i].word)) begin
        $error("sample_value: expected %0d actual %0d", vecs[i].value,
               convert_sample(vecs[i].fmt, vecs[i].word));
        err_count++;
      end
      send_word(vecs[i].word);
    end

    // random part: three idling phases, every format in each
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 47 : 0;
      for (int f = 0; f < 8; f++) begin
        fmt = 3'(f);
        if (f == 6) fmt = FMT_RSVD6;
        start <= 1'b0;
        write_format(fmt);
        for (int n = 0; n < ((f < 5) ? 120 : 20); n++) send_word(rand_word(fmt));
      end
    end
    start <= 1'b0;

    wait (sample_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ps2i_pkg.sv
rtl/core/ps2i_fscale.sv
rtl/core/pcm_sample_to_int24_top.sv
test/tb_pcm_sample_to_int24_top.sv
